[src/thceh_pkg.sv]
// Package for the two-hit chain energy histogram.
// Field widths, saturation limits, command codes and the result beat type.
// No dependencies.
`default_nettype none

package thceh_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned CHAIN_W  = 32;
    localparam int unsigned ENERGY_W = 16;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned BIN_W    = 8;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned SUM_W    = 20;
    localparam int unsigned HITS_W   = 2;

    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [HITS_W-1:0]  HITS_MAX  = 2'd3;
    localparam logic [HITS_W-1:0]  HITS_PAIR = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_HIT  = 2'd0,
        CMD_END  = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef struct packed {
        logic               filled;
        logic [BIN_W-1:0]   fill_bin;
        logic [COUNT_W-1:0] bin_count;
        logic [COUNT_W-1:0] total_entries;
    } result_t;

endpackage

`default_nettype wire

[src/thceh_if.sv]
// Handshake channels of the two-hit chain energy histogram: hit beats in,
// result beats out. Depends on thceh_pkg.
`default_nettype none

interface thceh_in_if;
    logic                             valid;
    logic                             ready;
    logic [thceh_pkg::CMD_W-1:0]      command;
    logic [thceh_pkg::CHAIN_W-1:0]    chain_id;
    logic [thceh_pkg::ENERGY_W-1:0]   energy_kev;
    logic [thceh_pkg::INDEX_W-1:0]    bin_index;

    modport source (output valid, command, chain_id, energy_kev, bin_index, input ready);
    modport sink   (input valid, command, chain_id, energy_kev, bin_index, output ready);
endinterface

interface thceh_out_if;
    logic                             valid;
    logic                             ready;
    logic                             filled;
    logic [thceh_pkg::BIN_W-1:0]      fill_bin;
    logic [thceh_pkg::COUNT_W-1:0]    bin_count;
    logic [thceh_pkg::COUNT_W-1:0]    total_entries;

    modport source (output valid, filled, fill_bin, bin_count, total_entries, input ready);
    modport sink   (input valid, filled, fill_bin, bin_count, total_entries, output ready);
endinterface

`default_nettype wire

[src/two_hit_chain_energy_histogram.sv]
// Two-hit chain energy histogram, top level: chain tracking, binning,
// histogram memory with read-modify-write and an output queue.
// Depends on thceh_pkg and thceh_if.
//
// Use:
//   hits    - sink channel. Each beat is a command: hit (chain_id, energy_kev),
//             end of stream (closes the open chain) or read of one bin
//             (bin_index, NUM_BINS is the overflow bin).
//   results - source channel. Exactly one beat per accepted command, in order:
//             filled / fill_bin when the command closed a two-hit chain,
//             bin_count for a read, and the running total_entries.
// Path: a result is shown once its command has passed binning and memory read,
//   update and queue write.
// Throughput: one command per cycle while hits.ready is high. Each command does
//   one read and at most one write of the histogram memory; back-to-back updates
//   of the same bin are served by forwarding the last written count.
// Reset: chain state and totals clear at once; the histogram memory is then
//   swept to zero, one bin per cycle over all NUM_BINS+1 bins, with hits.ready low.
// Stall: the pipeline never stops; a four-beat output queue absorbs results
//   and hits.ready drops when queue plus in-flight beats would exceed it.
`default_nettype none

module two_hit_chain_energy_histogram #(
    parameter int unsigned NUM_BINS      = 130,
    parameter int unsigned BIN_WIDTH_KEV = 20
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    thceh_in_if.sink      hits,
    thceh_out_if.source   results
);

    // ---------------------------------------------------------------
    // Derived sizes
    // ---------------------------------------------------------------
    localparam int unsigned DEPTH = NUM_BINS + 1;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned IW    = (AW > thceh_pkg::INDEX_W) ? AW : thceh_pkg::INDEX_W;

    // Division by the bin width as multiply by reciprocal:
    // q = (sum * RECIP) >> SHIFT, exact for every 20-bit sum.
    localparam int unsigned LOG_W  = $clog2(BIN_WIDTH_KEV);
    localparam int unsigned SHIFT  = thceh_pkg::SUM_W + LOG_W;
    localparam int unsigned RW     = thceh_pkg::SUM_W + 2;
    localparam int unsigned PW     = thceh_pkg::SUM_W + RW;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / 64'(BIN_WIDTH_KEV)) + 64'd1;
    localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

    // Output queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [thceh_pkg::CHAIN_W-1:0] prev_chain_reg, prev_chain_next;
    logic [thceh_pkg::HITS_W-1:0]  hits_reg, hits_next;
    logic [thceh_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [thceh_pkg::COUNT_W-1:0] total_reg, total_next;

    logic                          clr_active_reg, clr_active_next;
    logic [AW-1:0]                 clr_addr_reg, clr_addr_next;

    // stage 1: binning
    logic                          p1_valid_reg;
    logic                          p1_fill_reg, p1_fill_next;
    logic                          p1_rd_reg, p1_rd_next;
    logic [thceh_pkg::SUM_W-1:0]   p1_sum_reg, p1_sum_next;
    logic [AW-1:0]                 p1_idx_reg;

    // stage 2: update
    logic                          p2_valid_reg;
    logic                          p2_fill_reg;
    logic                          p2_rd_reg;
    logic [AW-1:0]                 p2_addr_reg;

    // last write, for forwarding
    logic                          fwd_valid_reg;
    logic [AW-1:0]                 fwd_addr_reg;
    logic [thceh_pkg::COUNT_W-1:0] fwd_data_reg;

    // histogram memory
    logic [thceh_pkg::COUNT_W-1:0] hist_mem [DEPTH];
    logic [thceh_pkg::COUNT_W-1:0] rdata_reg;

    // output queue
    thceh_pkg::result_t            q_mem [QDEPTH];
    logic [QAW-1:0]                q_wr_reg, q_rd_reg;
    logic [QCW-1:0]                q_cnt_reg, q_cnt_next;

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    logic       accept;
    logic [2:0] in_flight;
    logic       idx_ok;

    assign in_flight  = 3'(q_cnt_reg) + 3'(p1_valid_reg) + 3'(p2_valid_reg);
    assign hits.ready = !clr_active_reg && (in_flight < 3'(QDEPTH));
    assign accept     = hits.valid && hits.ready;
    assign idx_ok     = IW'(hits.bin_index) <= IW'(NUM_BINS);

    // Chain tracking, one beat per cycle while hits.ready is high
    always_comb
    begin
        logic                        same;
        logic [thceh_pkg::SUM_W:0]   wide_sum;
        same            = hits.chain_id == prev_chain_reg;
        wide_sum        = {1'b0, sum_reg} + (thceh_pkg::SUM_W + 1)'(hits.energy_kev);
        prev_chain_next = prev_chain_reg;
        hits_next       = hits_reg;
        sum_next        = sum_reg;
        p1_fill_next    = 1'b0;
        p1_rd_next      = 1'b0;
        p1_sum_next     = sum_reg;
        unique case (hits.command)
            thceh_pkg::CMD_HIT:
            begin
                if (same)
                begin
                    if (hits_reg != thceh_pkg::HITS_MAX)
                    begin
                        hits_next = hits_reg + 2'd1;
                    end
                    sum_next = wide_sum[thceh_pkg::SUM_W] ? thceh_pkg::SUM_MAX
                                                          : wide_sum[thceh_pkg::SUM_W-1:0];
                end
                else
                begin
                    p1_fill_next    = hits_reg == thceh_pkg::HITS_PAIR;
                    hits_next       = 2'd1;
                    prev_chain_next = hits.chain_id;
                    sum_next        = thceh_pkg::SUM_W'(hits.energy_kev);
                end
            end
            thceh_pkg::CMD_END:
            begin
                p1_fill_next = hits_reg == thceh_pkg::HITS_PAIR;
                hits_next    = '0;
                sum_next     = '0;
            end
            thceh_pkg::CMD_READ:
            begin
                p1_rd_next = idx_ok;
            end
            default:
            begin
                // unused code: no state change, result with only the running total
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_chain_reg <= '0;
            hits_reg       <= '0;
            sum_reg        <= '0;
            p1_valid_reg   <= 1'b0;
            p1_fill_reg    <= 1'b0;
            p1_rd_reg      <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            if (accept)
            begin
                prev_chain_reg <= prev_chain_next;
                hits_reg       <= hits_next;
                sum_reg        <= sum_next;
                p1_fill_reg    <= p1_fill_next;
                p1_rd_reg      <= p1_rd_next;
            end
            else
            begin
                p1_fill_reg <= 1'b0;
                p1_rd_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_sum_reg <= p1_sum_next;
            p1_idx_reg <= AW'(IW'(hits.bin_index));
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: bin number and memory read
    // ---------------------------------------------------------------
    logic [PW-1:0]                 prod;
    logic [thceh_pkg::SUM_W-1:0]   quot;
    logic [AW-1:0]                 bin;
    logic [AW-1:0]                 rd_addr;

    assign prod    = PW'(p1_sum_reg) * PW'(RECIP);
    assign quot    = thceh_pkg::SUM_W'(prod >> SHIFT);
    assign bin     = (quot >= thceh_pkg::SUM_W'(NUM_BINS)) ? LAST_BIN : AW'(quot);
    assign rd_addr = p1_fill_reg ? bin : p1_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
            p2_fill_reg  <= 1'b0;
            p2_rd_reg    <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= p1_valid_reg;
            p2_fill_reg  <= p1_fill_reg;
            p2_rd_reg    <= p1_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_addr_reg <= rd_addr;
    end

    // ---------------------------------------------------------------
    // Stage 2: modify, write back, queue the result
    // ---------------------------------------------------------------
    logic [thceh_pkg::COUNT_W-1:0] cur_count;
    logic [thceh_pkg::COUNT_W-1:0] new_count;
    logic                          upd_we;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [thceh_pkg::COUNT_W-1:0] wr_data;
    thceh_pkg::result_t            res;

    // The write of the previous beat lands at the same edge as this beat's read.
    assign cur_count = (fwd_valid_reg && (fwd_addr_reg == p2_addr_reg)) ? fwd_data_reg
                                                                         : rdata_reg;
    assign new_count = (cur_count == thceh_pkg::COUNT_MAX) ? cur_count
                                                           : cur_count + 32'd1;
    assign upd_we    = p2_valid_reg && p2_fill_reg;

    assign total_next = (upd_we && (total_reg != thceh_pkg::COUNT_MAX)) ? total_reg + 32'd1
                                                                         : total_reg;

    assign wr_en   = clr_active_reg || upd_we;
    assign wr_addr = clr_active_reg ? clr_addr_reg : p2_addr_reg;
    assign wr_data = clr_active_reg ? '0 : new_count;

    always_comb
    begin
        res.filled        = p2_fill_reg;
        res.fill_bin      = p2_fill_reg ? thceh_pkg::BIN_W'(p2_addr_reg) : '0;
        res.bin_count     = p2_rd_reg ? cur_count : '0;
        res.total_entries = total_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            fwd_valid_reg <= upd_we;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= p2_addr_reg;
        fwd_data_reg <= new_count;
    end

    // ---------------------------------------------------------------
    // Clearing sweep after reset
    // ---------------------------------------------------------------
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == LAST_BIN)
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // ---------------------------------------------------------------
    // Output queue
    // ---------------------------------------------------------------
    logic q_push;
    logic q_pop;

    assign q_push = p2_valid_reg;
    assign q_pop  = results.valid && results.ready;

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (q_push && !q_pop)
        begin
            q_cnt_next = q_cnt_reg + QCW'(1);
        end
        else if (!q_push && q_pop)
        begin
            q_cnt_next = q_cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (q_push)
            begin
                q_wr_reg <= q_wr_reg + QAW'(1);
            end
            if (q_pop)
            begin
                q_rd_reg <= q_rd_reg + QAW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem[q_wr_reg] <= res;
        end
    end

    assign results.valid         = q_cnt_reg != '0;
    assign results.filled        = q_mem[q_rd_reg].filled;
    assign results.fill_bin      = q_mem[q_rd_reg].fill_bin;
    assign results.bin_count     = q_mem[q_rd_reg].bin_count;
    assign results.total_entries = q_mem[q_rd_reg].total_entries;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_beat_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !p1_valid_reg && !p2_valid_reg)
        else $error("beat in flight during clearing sweep");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight <= 3'(QDEPTH))
        else $error("output queue credit exceeded");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_pop |-> q_cnt_reg < QCW'(QDEPTH))
        else $error("output queue overflow");

    a_total_steps: assert property (@(posedge clk) disable iff (!rst_n)
        !upd_we |=> total_reg == $past(total_reg))
        else $error("total changed without a fill");

    a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        upd_we |=> fwd_valid_reg && fwd_addr_reg == $past(p2_addr_reg))
        else $error("forwarding register lost a write");

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench for two_hit_chain_energy_histogram: directed and random command beats,
// a cycle-free predictor of the histogram, and a per-field scoreboard on the results.
// Depends on thceh_pkg, thceh_if and the top level of the block.

module tb;

    localparam int unsigned N_BINS      = 130;
    localparam int unsigned BIN_KEV     = 20;
    localparam int unsigned CLK_PERIOD  = 8;
    localparam int unsigned RESET_CYC   = 3;
    localparam int unsigned PHASE_BEATS = 256;
    // Silence limit: covers the post-reset sweep of all N_BINS+1 bins plus
    // very long random stall streaks on either side, many times over.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Wait after the last expected result, to catch a stray one.
    localparam int unsigned DRAIN_TAIL  = 8;
    localparam int unsigned PRINT_CAP   = 50;

    // Command code 3 is left unused by the block and must be ignored.
    localparam logic [thceh_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Idling pattern that goes with each beat.
    typedef enum int unsigned {
        PACE_FREE,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct {
        logic [thceh_pkg::CMD_W-1:0]    command;
        logic [thceh_pkg::CHAIN_W-1:0]  chain_id;
        logic [thceh_pkg::ENERGY_W-1:0] energy_kev;
        logic [thceh_pkg::INDEX_W-1:0]  bin_index;
        pace_t                          pace;
    } hit_item_t;

    logic clk = 1'b0;
    logic rst_n;

    thceh_in_if  hits_if ();
    thceh_out_if results_if ();

    two_hit_chain_energy_histogram #(
        .NUM_BINS      (N_BINS),
        .BIN_WIDTH_KEV (BIN_KEV)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .hits    (hits_if),
        .results (results_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: the open chain, the bin counts and the fill total.
    // ------------------------------------------------------------------
    logic [thceh_pkg::CHAIN_W-1:0] open_chain_id;
    logic [thceh_pkg::HITS_W-1:0]  open_hits;
    logic [thceh_pkg::SUM_W-1:0]   open_sum;
    logic [thceh_pkg::COUNT_W-1:0] bin_counts [0:N_BINS];
    logic [thceh_pkg::COUNT_W-1:0] fills_so_far;

    hit_item_t          hit_queue [$];
    thceh_pkg::result_t predicted_results [$];
    hit_item_t          beat_on_bus;
    pace_t              live_pace = PACE_FREE;
    pace_t              gen_pace  = PACE_FREE;
    thceh_pkg::result_t seen;
    thceh_pkg::result_t want;

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    function automatic bit chance(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic flag_mismatch(string what, logic [thceh_pkg::COUNT_W-1:0] got,
                                 logic [thceh_pkg::COUNT_W-1:0] exp_val);
        if (mismatch_count < PRINT_CAP)
            $display("tb: %0t ns: %s: got %0h, want %0h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    // Close the open chain; only a chain of exactly two hits fills a bin.
    // Sums beyond the last regular bin land in the overflow bin.
    function automatic void close_open_chain(inout thceh_pkg::result_t r);
        logic [thceh_pkg::SUM_W-1:0] bin;
        if (open_hits != thceh_pkg::HITS_PAIR)
            return;
        bin = thceh_pkg::SUM_W'(open_sum / BIN_KEV);
        if (bin >= N_BINS)
            bin = thceh_pkg::SUM_W'(N_BINS);
        if (bin_counts[bin] != thceh_pkg::COUNT_MAX)
            bin_counts[bin]++;
        if (fills_so_far != thceh_pkg::COUNT_MAX)
            fills_so_far++;
        r.filled   = 1'b1;
        r.fill_bin = bin[thceh_pkg::BIN_W-1:0];
    endfunction

    // One command in, one result out; updates the predictor state.
    function automatic thceh_pkg::result_t histogram_predict(hit_item_t it);
        thceh_pkg::result_t        r;
        logic [thceh_pkg::SUM_W:0] widened;
        r = '0;
        case (it.command)
            thceh_pkg::CMD_HIT:
            begin
                if (it.chain_id == open_chain_id)
                begin
                    if (open_hits != thceh_pkg::HITS_MAX)
                        open_hits++;
                    widened  = {1'b0, open_sum} + (thceh_pkg::SUM_W + 1)'(it.energy_kev);
                    open_sum = (widened > thceh_pkg::SUM_MAX) ? thceh_pkg::SUM_MAX
                                                              : widened[thceh_pkg::SUM_W-1:0];
                end
                else
                begin
                    close_open_chain(r);
                    open_hits     = 2'd1;
                    open_chain_id = it.chain_id;
                    open_sum      = thceh_pkg::SUM_W'(it.energy_kev);
                end
            end
            thceh_pkg::CMD_END:
            begin
                // chain number is kept: a later hit with it opens a fresh chain
                close_open_chain(r);
                open_hits = '0;
                open_sum  = '0;
            end
            thceh_pkg::CMD_READ:
            begin
                if (it.bin_index <= N_BINS)
                    r.bin_count = bin_counts[it.bin_index];
            end
            default: ;
        endcase
        r.total_entries = fills_so_far;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(logic [thceh_pkg::CMD_W-1:0] cmd, int unsigned chain,
                             int unsigned energy, int unsigned index);
        hit_item_t it;
        it.command    = cmd;
        it.chain_id   = chain;
        it.energy_kev = thceh_pkg::ENERGY_W'(energy);
        it.bin_index  = thceh_pkg::INDEX_W'(index);
        it.pace       = gen_pace;
        hit_queue.push_back(it);
    endtask

    // Mostly small energies so two-hit sums spread over the regular bins;
    // some full-range values and the bin edges around the overflow limit.
    function automatic int unsigned pick_energy();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 1400);
        if (r < 85)
            return $urandom();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 65535;
            2:       return 1299;
            default: return 1300;
        endcase
    endfunction

    // New chain number, never the one that is open, so the chain closes.
    function automatic logic [thceh_pkg::CHAIN_W-1:0] fresh_chain(
            logic [thceh_pkg::CHAIN_W-1:0] last);
        logic [thceh_pkg::CHAIN_W-1:0] id;
        int unsigned                   r;
        r = $urandom_range(0, 99);
        if (r < 50)
            id = $urandom();
        else if (r < 90)
            id = $urandom_range(0, 7);
        else
            id = (r < 95) ? '0 : '1;
        if (id == last)
            id[0] = ~id[0];
        return id;
    endfunction

    function automatic int unsigned pick_index();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, N_BINS);
        if (r < 80)
            return $urandom();
        return $urandom_range(N_BINS - 1, N_BINS + 1);
    endfunction

    // ------------------------------------------------------------------
    // Driver: takes beats from hit_queue, holds each until accepted.
    // Prediction is made at the edge of acceptance.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_if.valid      <= 1'b0;
            hits_if.command    <= thceh_pkg::CMD_HIT;
            hits_if.chain_id   <= '0;
            hits_if.energy_kev <= '0;
            hits_if.bin_index  <= '0;
        end
        else
        begin
            if (hits_if.valid && hits_if.ready)
                predicted_results.push_back(histogram_predict(beat_on_bus));
            if (!hits_if.valid || hits_if.ready)
            begin
                if (hit_queue.size() != 0 &&
                    !chance(hit_queue[0].pace == PACE_SRC_IDLE ? 62 :
                            hit_queue[0].pace == PACE_BOTH     ? 21 : 0))
                begin
                    beat_on_bus = hit_queue.pop_front();
                    live_pace          <= beat_on_bus.pace;
                    hits_if.valid      <= 1'b1;
                    hits_if.command    <= beat_on_bus.command;
                    hits_if.chain_id   <= beat_on_bus.chain_id;
                    hits_if.energy_kev <= beat_on_bus.energy_kev;
                    hits_if.bin_index  <= beat_on_bus.bin_index;
                end
                else
                begin
                    hits_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: result beats against the oldest prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                seen.filled        = results_if.filled;
                seen.fill_bin      = results_if.fill_bin;
                seen.bin_count     = results_if.bin_count;
                seen.total_entries = results_if.total_entries;
                if (predicted_results.size() == 0)
                begin
                    flag_mismatch("result with nothing expected, total_entries",
                                  seen.total_entries, '0);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (seen.filled !== want.filled)
                        flag_mismatch("filled", thceh_pkg::COUNT_W'(seen.filled),
                                      thceh_pkg::COUNT_W'(want.filled));
                    if (seen.fill_bin !== want.fill_bin)
                        flag_mismatch("fill_bin", thceh_pkg::COUNT_W'(seen.fill_bin),
                                      thceh_pkg::COUNT_W'(want.fill_bin));
                    if (seen.bin_count !== want.bin_count)
                        flag_mismatch("bin_count", seen.bin_count, want.bin_count);
                    if (seen.total_entries !== want.total_entries)
                        flag_mismatch("total_entries", seen.total_entries,
                                      want.total_entries);
                end
            end
            results_if.ready <= !chance(live_pace == PACE_SNK_STALL ? 62 :
                                        live_pace == PACE_BOTH      ? 21 : 0);
        end
    end

    // Watchdog: cycles with no beat on either side.
    always @(posedge clk)
    begin
        if ((hits_if.valid && hits_if.ready) || (results_if.valid && results_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [thceh_pkg::CHAIN_W-1:0] id;
        logic [thceh_pkg::CHAIN_W-1:0] last_id;
        int unsigned                   roll;
        int unsigned                   target;
        int unsigned                   n;

        rst_n = 1'b0;

        open_chain_id = '0;
        open_hits     = '0;
        open_sum      = '0;
        fills_so_far  = '0;
        for (int b = 0; b <= N_BINS; b++)
            bin_counts[b] = '0;

        // Directed beats, no idling.
        gen_pace = PACE_FREE;
        // first hit with chain 0 continues the empty chain: no fill
        push_item(thceh_pkg::CMD_HIT, 32'd0, 0, $urandom());
        push_item(thceh_pkg::CMD_HIT, 32'd0, 5, $urandom());
        push_item(thceh_pkg::CMD_END, $urandom(), $urandom(), $urandom());   // fills bin 0
        push_item(thceh_pkg::CMD_END, $urandom(), $urandom(), $urandom());   // nothing open
        push_item(thceh_pkg::CMD_READ, $urandom(), $urandom(), 0);
        // chain number kept after end of stream: same number opens afresh
        push_item(thceh_pkg::CMD_HIT, 32'd0, 7, $urandom());
        push_item(thceh_pkg::CMD_HIT, '1, '1, $urandom());                   // closes single hit
        push_item(thceh_pkg::CMD_HIT, '1, '1, $urandom());
        push_item(thceh_pkg::CMD_HIT, 32'd10, 1299, $urandom());             // overflow fill
        push_item(thceh_pkg::CMD_HIT, 32'd10, 1300, $urandom());             // sum 2599
        push_item(thceh_pkg::CMD_HIT, 32'd11, 1300, $urandom());             // last regular bin
        push_item(thceh_pkg::CMD_HIT, 32'd11, 1300, $urandom());             // sum 2600
        push_item(thceh_pkg::CMD_HIT, 32'd11, 1, $urandom());                // count saturates
        push_item(thceh_pkg::CMD_HIT, 32'd11, 1, $urandom());
        push_item(thceh_pkg::CMD_END, $urandom(), $urandom(), $urandom());   // three hits
        push_item(thceh_pkg::CMD_HIT, 32'd12, 19, $urandom());
        push_item(thceh_pkg::CMD_HIT, 32'd12, 1, $urandom());
        push_item(thceh_pkg::CMD_END, $urandom(), $urandom(), $urandom());   // bin 1
        push_item(thceh_pkg::CMD_READ, $urandom(), $urandom(), N_BINS);
        push_item(thceh_pkg::CMD_READ, $urandom(), $urandom(), N_BINS - 1);
        push_item(thceh_pkg::CMD_READ, $urandom(), $urandom(), N_BINS + 1);  // out of range
        push_item(thceh_pkg::CMD_READ, $urandom(), $urandom(), 255);
        push_item(CMD_UNUSED, $urandom(), $urandom(), $urandom());
        push_item(thceh_pkg::CMD_HIT, 32'd12, 0, $urandom());
        push_item(thceh_pkg::CMD_READ, $urandom(), $urandom(), 1);
        last_id = 32'd12;

        // Random part, one block of beats per idling pattern.
        for (int m = 0; m < 4; m++)
        begin
            gen_pace = pace_t'(m);
            target   = hit_queue.size() + PHASE_BEATS;
            while (hit_queue.size() < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                begin
                    // well-formed two-hit chain, sometimes with end of stream
                    id = fresh_chain(last_id);
                    push_item(thceh_pkg::CMD_HIT, id, pick_energy(), $urandom());
                    push_item(thceh_pkg::CMD_HIT, id, pick_energy(), $urandom());
                    last_id = id;
                    if (roll < 6)
                        push_item(thceh_pkg::CMD_END, $urandom(), $urandom(), $urandom());
                end
                else if (roll < 55)
                begin
                    id = fresh_chain(last_id);
                    push_item(thceh_pkg::CMD_HIT, id, pick_energy(), $urandom());
                    last_id = id;
                end
                else if (roll < 63)
                begin
                    id = fresh_chain(last_id);
                    n  = $urandom_range(3, 5);
                    repeat (n)
                        push_item(thceh_pkg::CMD_HIT, id, pick_energy(), $urandom());
                    last_id = id;
                end
                else if (roll < 75)
                begin
                    push_item(thceh_pkg::CMD_END, $urandom(), $urandom(), $urandom());
                end
                else if (roll < 87)
                begin
                    push_item(thceh_pkg::CMD_READ, $urandom(), $urandom(), pick_index());
                end
                else if (roll < 92)
                begin
                    push_item(CMD_UNUSED, $urandom(), $urandom(), $urandom());
                end
                else if (roll < 97)
                begin
                    // joins whatever is open, or reopens after end of stream
                    push_item(thceh_pkg::CMD_HIT, last_id, pick_energy(), $urandom());
                end
                else
                begin
                    // long chain of big hits: energy sum saturates
                    id = fresh_chain(last_id);
                    n  = $urandom_range(17, 20);
                    repeat (n)
                        push_item(thceh_pkg::CMD_HIT, id, $urandom_range(65000, 65535),
                                  $urandom());
                    last_id = id;
                end
            end
        end

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every beat is in and every result is out, or silence.
        @(negedge clk);
        while (!(hit_queue.size() == 0 && !hits_if.valid && predicted_results.size() == 0)
               && quiet_cycles < QUIET_LIMIT)
            @(negedge clk);

        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: %0t ns: no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, predicted_results.size());
            $display("tb: done, errors");
        end
        else
        begin
            // catch any stray result after the last expected one
            repeat (DRAIN_TAIL) @(negedge clk);
            if (mismatch_count == 0 && predicted_results.size() == 0)
                $display("tb: done, clean");
            else
                $display("tb: done, errors");
        end
        $finish;
    end

endmodule
